>>> rtl/core/assert_macros.svh
// Assertion macros shared by the cursor overlay RTL.
// Each macro wraps one clocked concurrent assertion on clk, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk outside reset.
`define CSOV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Implication: when cond holds, prop must hold in the next cycle.
`define CSOV_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/core/csov_pkg.sv
// Shared types, constants and shape functions for the cursor sprite overlay.
// No dependencies; used by csov_shape_rom and cursor_sprite_overlay.
package csov_pkg;

  localparam int PIX_W      = 12;
  localparam int COLOR_W    = 32;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int SHAPE_ROWS = 32;
  localparam int MASK_W     = 16;

  localparam logic [COLOR_W-1:0] COLOR_BODY = 32'h00FF_FFFF;
  localparam logic [COLOR_W-1:0] COLOR_EDGE = 32'h0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURSOR_X      = 2'd0,
    CFG_CURSOR_Y      = 2'd1,
    CFG_CURSOR_ENABLE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PART_BG   = 2'd0,
    PART_BODY = 2'd1,
    PART_EDGE = 2'd2
  } part_t;

  // Arrow body, bit 0 is the leftmost column of the box.
  localparam logic [7:0] ARROW_BODY [SHAPE_ROWS] = '{
    8'h01, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h3F, 8'h7F, 8'hFF,
    8'h1F, 8'h1B, 8'h31, 8'h30, 8'h60, 8'h60, 8'hC0, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  function automatic logic [MASK_W-1:0] body_row(input int r, input int h);
    logic [MASK_W-1:0] m;
    m = '0;
    if (r >= 0 && r < h && r < SHAPE_ROWS) begin
      m = MASK_W'(ARROW_BODY[r]);
    end
    return m;
  endfunction

  // Dilate the body by one pixel in each direction, clip to the box width, drop the body itself.
  function automatic logic [MASK_W-1:0] halo_row(input int r, input int h, input int w);
    logic [MASK_W-1:0] m;
    logic [MASK_W-1:0] box;
    m   = body_row(r - 1, h) | body_row(r, h) | body_row(r + 1, h);
    box = MASK_W'((32'd1 << w) - 32'd1);
    m   = (m | (m << 1) | (m >> 1)) & box;
    return m & ~body_row(r, h);
  endfunction

endpackage

>>> rtl/core/csov_shape_rom.sv
// Cursor shape lookup: body and outline masks of one cursor row.
// Depends on csov_pkg for the arrow table and mask functions.
module csov_shape_rom #(
  parameter int CURSOR_WIDTH  = 11,
  parameter int CURSOR_HEIGHT = 18
) (
  input  logic [$clog2(CURSOR_HEIGHT)-1:0] row,
  output logic [CURSOR_WIDTH-1:0]          body_mask,
  output logic [CURSOR_WIDTH-1:0]          outline_mask
);

  logic [CURSOR_WIDTH-1:0] body_tbl    [CURSOR_HEIGHT];
  logic [CURSOR_WIDTH-1:0] outline_tbl [CURSOR_HEIGHT];

  for (genvar r = 0; r < CURSOR_HEIGHT; r++) begin : g_row
    assign body_tbl[r]    = CURSOR_WIDTH'(csov_pkg::body_row(r, CURSOR_HEIGHT));
    assign outline_tbl[r] = CURSOR_WIDTH'(csov_pkg::halo_row(r, CURSOR_HEIGHT,
                                                             CURSOR_WIDTH));
  end

  always_comb begin
    body_mask    = '0;
    outline_mask = '0;
    if (32'(row) < CURSOR_HEIGHT) begin
      body_mask    = body_tbl[row];
      outline_mask = outline_tbl[row];
    end
  end

endmodule

>>> rtl/core/cursor_sprite_overlay.sv
// Hardware arrow cursor overlay on a pixel stream.
// Input stream in_*: one pixel per transfer; tdata = {background_color[31:0],
//   pixel_y[11:0], pixel_x[11:0]} from bit 55 down to bit 0.
// Output stream out_*: one result per input pixel, in order; tdata carries the
//   displayed color word, tuser the cursor part (0 background, 1 body, 2 outline).
// Config port cfg_*: index 0 cursor_x, 1 cursor_y (signed box corner),
//   2 cursor_enable; always ready; to be written by users between frames while the
//   stream is idle; the block itself does not enforce this. Each pixel passes three
//   register stages (offset subtract, shape table lookup, output color select).
// Throughput: one pixel per clock while the receiver does not stall.
// Reset (rst_n low, synchronous) clears all stage valid bits and the cursor
//   registers: position 0,0, cursor disabled.
// When the receiver stalls, the output holds its transfer; each stage keeps
//   filling bubbles behind it, and in_tready drops only once all stages are full.
// Depends on csov_pkg, csov_shape_rom and assert_macros.svh.
`include "assert_macros.svh"

module cursor_sprite_overlay #(
  parameter int CURSOR_WIDTH  = 11,
  parameter int CURSOR_HEIGHT = 18,
  parameter int COORD_BITS    = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: pixel_x[11:0], pixel_y[23:12], background_color[55:24]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,
  // out_tdata: pixel_color[31:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // out_tuser: cursor_part[1:0]
  output logic [1:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [csov_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csov_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int PW = csov_pkg::PIX_W;
  localparam int DW = COORD_BITS + 2;
  localparam int CW = $clog2(CURSOR_WIDTH);
  localparam int RW = $clog2(CURSOR_HEIGHT);

  // ---------------- configuration registers ----------------
  logic signed [COORD_BITS-1:0] cursor_x_r, cursor_y_r;
  logic                         cursor_en_r;
  logic signed [COORD_BITS-1:0] cfg_coord;

  if (COORD_BITS >= csov_pkg::CFG_DATA_W) begin : g_cfg_ext
    assign cfg_coord = COORD_BITS'(signed'(cfg_data));
  end else begin : g_cfg_trunc
    assign cfg_coord = signed'(cfg_data[COORD_BITS-1:0]);
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      cursor_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        csov_pkg::CFG_CURSOR_X:      cursor_x_r  <= cfg_coord;
        csov_pkg::CFG_CURSOR_Y:      cursor_y_r  <= cfg_coord;
        csov_pkg::CFG_CURSOR_ENABLE: cursor_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- stage enables ----------------
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  assign en3       = !v3_r || out_tready;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  // ---------------- stage 1: offsets into the cursor box ----------------
  logic [COORD_BITS-1:0] px_c, py_c;

  if (COORD_BITS >= PW) begin : g_pix_ext
    assign px_c = COORD_BITS'(in_tdata[PW-1:0]);
    assign py_c = COORD_BITS'(in_tdata[2*PW-1:PW]);
  end else begin : g_pix_trunc
    assign px_c = in_tdata[COORD_BITS-1:0];
    assign py_c = in_tdata[PW+COORD_BITS-1:PW];
  end

  logic signed [DW-1:0]    dx1_r, dy1_r, dx1_nxt, dy1_nxt;
  logic                    en_1_r;
  logic [csov_pkg::COLOR_W-1:0] bg1_r;

  assign dx1_nxt = signed'({2'b00, px_c}) - DW'(cursor_x_r);
  assign dy1_nxt = signed'({2'b00, py_c}) - DW'(cursor_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_tvalid) begin
      dx1_r  <= dx1_nxt;
      dy1_r  <= dy1_nxt;
      en_1_r <= cursor_en_r;
      bg1_r  <= in_tdata[2*PW+csov_pkg::COLOR_W-1:2*PW];
    end
  end

  // ---------------- stage 2: box test and shape lookup ----------------
  logic                    in_box;
  logic [CURSOR_WIDTH-1:0] body_mask, outline_mask;
  logic                    body2_r, outline2_r, body2_nxt, outline2_nxt;
  logic [csov_pkg::COLOR_W-1:0] bg2_r;

  assign in_box = en_1_r
               && !dx1_r[DW-1] && (dx1_r[DW-2:0] < (DW-1)'(CURSOR_WIDTH))
               && !dy1_r[DW-1] && (dy1_r[DW-2:0] < (DW-1)'(CURSOR_HEIGHT));

  csov_shape_rom #(
    .CURSOR_WIDTH  (CURSOR_WIDTH),
    .CURSOR_HEIGHT (CURSOR_HEIGHT)
  ) u_shape (
    .row          (dy1_r[RW-1:0]),
    .body_mask    (body_mask),
    .outline_mask (outline_mask)
  );

  // column index is only meaningful inside the box
  assign body2_nxt    = in_box && body_mask[dx1_r[CW-1:0]];
  assign outline2_nxt = in_box && outline_mask[dx1_r[CW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      body2_r    <= body2_nxt;
      outline2_r <= outline2_nxt;
      bg2_r      <= bg1_r;
    end
  end

  // ---------------- stage 3: output register ----------------
  logic [csov_pkg::COLOR_W-1:0] color3_r, color3_nxt;
  csov_pkg::part_t              part3_r, part3_nxt;

  always_comb begin
    priority if (body2_r) begin
      color3_nxt = csov_pkg::COLOR_BODY;
      part3_nxt  = csov_pkg::PART_BODY;
    end else if (outline2_r) begin
      color3_nxt = csov_pkg::COLOR_EDGE;
      part3_nxt  = csov_pkg::PART_EDGE;
    end else begin
      color3_nxt = bg2_r;
      part3_nxt  = csov_pkg::PART_BG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      color3_r <= color3_nxt;
      part3_r  <= part3_nxt;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = color3_r;
  assign out_tuser  = part3_r;

  // ---------------- assertions ----------------
  `CSOV_ASSERT(a_body_white, !(out_tvalid && out_tuser == csov_pkg::PART_BODY) || out_tdata == csov_pkg::COLOR_BODY, "body pixel not white")
  `CSOV_ASSERT(a_edge_black, !(out_tvalid && out_tuser == csov_pkg::PART_EDGE) || out_tdata == csov_pkg::COLOR_EDGE, "outline pixel not black")
  `CSOV_ASSERT(a_masks_disjoint, !(v2_r && body2_r && outline2_r), "body and outline both hit")
  `CSOV_ASSERT(a_stall_full, in_tready || (v1_r && v2_r && v3_r && !out_tready), "input stalled with a bubble in the pipe")
  `CSOV_ASSERT_NEXT(a_stage_advance, v2_r && en3, out_tvalid, "stage 2 item lost on advance")

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for cursor_sprite_overlay: pixel stream in, overlaid pixel out.
// A scoreboard class predicts each output pixel from its own copy of the arrow shape and
// the cursor registers; depends on csov_pkg and the RTL under rtl/core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_DEPTH = 3;
  localparam logic [csov_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct packed {
    logic [31:0]     color;
    csov_pkg::part_t part;
  } overlay_pix_t;

  class overlay_scoreboard;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic               shown;
    overlay_pix_t       expected_q[$];
    int                 errors;

    function new();
      pos_x  = '0;
      pos_y  = '0;
      shown  = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [csov_pkg::CFG_IDX_W-1:0] idx,
                            logic [csov_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        csov_pkg::CFG_CURSOR_X:      pos_x = d;
        csov_pkg::CFG_CURSOR_Y:      pos_y = d;
        csov_pkg::CFG_CURSOR_ENABLE: shown = d[0];
        default: ;
      endcase
    endfunction

    // Arrow rows, bit 0 = leftmost box column; rows past the shape are empty.
    function logic [10:0] arrow_bits(int r);
      case (r)
        0:  return 11'h001;
        1:  return 11'h003;
        2:  return 11'h007;
        3:  return 11'h00F;
        4:  return 11'h01F;
        5:  return 11'h03F;
        6:  return 11'h07F;
        7:  return 11'h0FF;
        8:  return 11'h01F;
        9:  return 11'h01B;
        10: return 11'h031;
        11: return 11'h030;
        12: return 11'h060;
        13: return 11'h060;
        14: return 11'h0C0;
        default: return 11'h000;
      endcase
    endfunction

    // 3x3 dilation of the body, cut to the 11-column box, minus the body itself.
    function logic [10:0] rim_bits(int r);
      logic [10:0] m;
      m = arrow_bits(r - 1) | arrow_bits(r) | arrow_bits(r + 1);
      m = m | {m[9:0], 1'b0} | {1'b0, m[10:1]};
      return m & ~arrow_bits(r);
    endfunction

    function overlay_pix_t overlay(logic [11:0] px, logic [11:0] py, logic [31:0] bg);
      overlay_pix_t res;
      int dx;
      int dy;
      logic [10:0] body_m;
      logic [10:0] rim_m;
      res.color = bg;
      res.part  = csov_pkg::PART_BG;
      dx = int'(px) - int'(pos_x);
      dy = int'(py) - int'(pos_y);
      if (shown && dx >= 0 && dx < 11 && dy >= 0 && dy < 18) begin
        body_m = arrow_bits(dy);
        rim_m  = rim_bits(dy);
        if (body_m[dx]) begin
          res.color = csov_pkg::COLOR_BODY;
          res.part  = csov_pkg::PART_BODY;
        end else if (rim_m[dx]) begin
          res.color = csov_pkg::COLOR_EDGE;
          res.part  = csov_pkg::PART_EDGE;
        end
      end
      return res;
    endfunction

    function void note_pixel(logic [55:0] d);
      expected_q.push_back(overlay(d[11:0], d[23:12], d[55:24]));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_pixel(logic [31:0] color, logic [1:0] part);
      overlay_pix_t exp_pix;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected output color=%h part=%0d", color, part));
      end else begin
        exp_pix = expected_q.pop_front();
        if (color !== exp_pix.color)
          report($sformatf("pixel_color %h, want %h", color, exp_pix.color));
        if (part !== exp_pix.part)
          report($sformatf("cursor_part %0d, want %0d", part, exp_pix.part));
      end
    endtask
  endclass

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [55:0]                     in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [31:0]                     out_tdata;
  logic [1:0]                      out_tuser;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [csov_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [csov_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  overlay_scoreboard sb;

  cursor_sprite_overlay dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pixel(out_tdata, out_tuser);
  end

  task automatic send_pixel(logic [11:0] px, logic [11:0] py, logic [31:0] bg);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {bg, py, px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pixel({bg, py, px});
  endtask

  // Hold the stream until every pixel in flight has come out.
  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [csov_pkg::CFG_IDX_W-1:0] idx,
                           logic [csov_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic set_cursor(int x, int y, bit en, bit poke_spare);
    drain_pipe();
    if (poke_spare) write_reg(CFG_SPARE_IDX, 12'($urandom));
    write_reg(csov_pkg::CFG_CURSOR_X, 12'(x));
    write_reg(csov_pkg::CFG_CURSOR_Y, 12'(y));
    write_reg(csov_pkg::CFG_CURSOR_ENABLE, {11'($urandom), en});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int cx;
    int cy;
    logic [11:0] px;
    logic [11:0] py;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // cursor disabled out of reset: everything passes
    send_pixel(12'd0, 12'd0, 32'h0000_0000);
    send_pixel(12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
    send_pixel(12'd5, 12'd3, $urandom);

    set_cursor(0, 0, 1'b1, 1'b0);
    send_pixel(12'd0, 12'd0, $urandom);   // body tip
    send_pixel(12'd1, 12'd0, $urandom);   // outline
    send_pixel(12'd2, 12'd0, $urandom);   // outline
    send_pixel(12'd8, 12'd7, $urandom);   // outline right of widest row
    send_pixel(12'd6, 12'd15, $urandom);  // outline below the shape
    send_pixel(12'd6, 12'd16, $urandom);  // empty rows past the shape
    send_pixel(12'd10, 12'd17, $urandom); // box corner
    send_pixel(12'd11, 12'd0, $urandom);  // just right of the box
    send_pixel(12'd0, 12'd18, $urandom);  // just below the box

    // box hanging off the top-left corner, spare index must be ignored
    set_cursor(-3, -2, 1'b1, 1'b1);
    send_pixel(12'd0, 12'd0, $urandom);

    set_cursor(2047, 2047, 1'b1, 1'b0);
    send_pixel(12'd2047, 12'd2047, $urandom);
    send_pixel(12'hFFF, 12'hFFF, $urandom);

    set_cursor(-2048, -2048, 1'b1, 1'b0);
    send_pixel(12'd0, 12'd0, $urandom);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 31; rx_idle_pct = 50; end
        1: begin tx_idle_pct = 50; rx_idle_pct = 31; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int blk = 0; blk < 12; blk++) begin
        case (blk % 6)
          0: set_cursor(-2048, 2047, 1'b1, 1'b0);
          1: set_cursor(2047, -2048, 1'b1, 1'b1);
          2: set_cursor($urandom_range(40), $urandom_range(40), 1'b0, 1'b0);
          3: set_cursor(-$urandom_range(1, 12), -$urandom_range(1, 19), 1'b1, 1'b0);
          default: set_cursor($urandom_range(2047), $urandom_range(2047), 1'b1,
                              $urandom_range(3) == 0);
        endcase
        cx = int'(sb.pos_x);
        cy = int'(sb.pos_y);
        for (int i = 0; i < 32; i++) begin
          if (blk == 7 && i == 16) drain_pipe();
          if ($urandom_range(3) != 0) begin
            px = 12'(cx + $urandom_range(14) - 2);
            py = 12'(cy + $urandom_range(21) - 2);
          end else begin
            px = 12'($urandom);
            py = 12'($urandom);
          end
          send_pixel(px, py, $urandom);
        end
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout waiting for output pixels");
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/csov_pkg.sv
rtl/core/csov_shape_rom.sv
rtl/core/cursor_sprite_overlay.sv
verif/tb_top.sv
